// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files that carry checks; page_bitmap_allocator.sv includes them.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

// ----- rtl/pba_pkg.sv -----
package pba_pkg;

    // Width of a page number and of the exported free map.
    localparam int PAGE_W    = 5;
    localparam int OUT_MAP_W = 32;

    // Pool size after reset.
    localparam logic [PAGE_W-1:0] TOTAL_PAGES_RESET = 5'd31;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_RESIZE = 2'd2,
        REQ_RESET  = 2'd3
    } req_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DECIDE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- rtl/page_bitmap_allocator.sv -----
// Page allocator over a MAP_BITS-wide free map (set bit = free page). One request is taken
// at a time and the block holds in_ready low until it has finished; the result sits in an
// output register, so a new request can be taken while the previous result waits. Free,
// reset, shrink and in-place growth pass through SHIFT, DECIDE and FINISH; FINISH holds
// until the output register is free, loads it and returns to IDLE for the next request.
// Allocate, and a resize that must move, run a first-fit scan that tests one start position
// per cycle with a single mask compare against a shifting candidate mask, from page 0 up
// to the last start at which the run still fits in the map; the scan ends at the first
// fit or, when none fits, with a failure, and then passes through FINISH as above.
// The register total_pages sets how many pages a reset request marks free; it is written
// with cfg_wr_en.
`include "assert_macros.svh"

module page_bitmap_allocator #(
    parameter int MAP_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic [pba_pkg::PAGE_W-1:0]          cfg_wr_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [pba_pkg::PAGE_W-1:0]          start_page,
    input  logic [pba_pkg::PAGE_W-1:0]          old_count,
    input  logic [pba_pkg::PAGE_W-1:0]          page_count,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic [pba_pkg::PAGE_W-1:0]          result_page,
    output logic                                moved,
    output logic [pba_pkg::OUT_MAP_W-1:0]       free_map_out
);

    localparam int SW    = $clog2(MAP_BITS + 1);
    localparam int SUM_W = $clog2(MAP_BITS + 32);
    localparam int PW    = pba_pkg::PAGE_W;

    // Mask with the low n bits set, limited to the map width.
    function automatic logic [MAP_BITS-1:0] run_mask(input logic [PW-1:0] n);
        logic [MAP_BITS-1:0] m;
        for (int i = 0; i < MAP_BITS; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    pba_pkg::state_t      state_reg, state_next;
    logic [PW-1:0]        total_pages_reg;

    pba_pkg::req_t        req_reg, req_next;
    logic [PW-1:0]        start_reg, start_next;
    logic [PW-1:0]        oldc_reg, oldc_next;
    logic [PW-1:0]        cnt_reg, cnt_next;

    logic [MAP_BITS-1:0]  free_map_reg, free_map_next;
    logic [MAP_BITS-1:0]  cnt_sh_reg, cnt_sh_next;
    logic [MAP_BITS-1:0]  old_sh_reg, old_sh_next;
    logic [MAP_BITS-1:0]  cand_reg, cand_next;
    logic [SW-1:0]        s_reg, s_next;

    logic                 res_ok_reg, res_ok_next;
    logic [PW-1:0]        res_page_reg, res_page_next;
    logic                 res_moved_reg, res_moved_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg, out_ok_next;
    logic [PW-1:0]        out_page_reg, out_page_next;
    logic                 out_moved_reg, out_moved_next;
    logic [pba_pkg::OUT_MAP_W-1:0] out_map_reg, out_map_next;

    logic                 accept;
    logic                 slot_free;
    logic [MAP_BITS-1:0]  delta;
    logic                 old_busy;
    logic                 grow;
    logic                 ext_fits;
    logic                 ext_free;
    logic                 need_scan;
    logic                 limit_ok;
    logic                 hit;
    logic                 map_quiet;
    logic                 in_scan;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Decisions taken once the run masks have been shifted into place.
    assign delta     = cnt_sh_reg ^ old_sh_reg;
    assign old_busy  = |(free_map_reg & old_sh_reg);
    assign grow      = cnt_reg > oldc_reg;
    assign ext_fits  = (SUM_W'(start_reg) + SUM_W'(cnt_reg)) <= SUM_W'(MAP_BITS);
    assign ext_free  = (free_map_reg & delta) == delta;
    assign need_scan = (req_reg == pba_pkg::REQ_ALLOC)
                    || ((req_reg == pba_pkg::REQ_RESIZE) && !old_busy && grow
                        && !(ext_fits && ext_free));

    // Shared compare unit of the first-fit scan: one start position per cycle.
    assign limit_ok  = (SUM_W'(s_reg) + SUM_W'(cnt_reg)) <= SUM_W'(MAP_BITS);
    assign hit       = limit_ok && ((free_map_reg & cand_reg) == cand_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pba_pkg::ST_SHIFT;
                end
            end
            pba_pkg::ST_SHIFT:
            begin
                state_next = pba_pkg::ST_DECIDE;
            end
            pba_pkg::ST_DECIDE:
            begin
                state_next = need_scan ? pba_pkg::ST_SCAN : pba_pkg::ST_FINISH;
            end
            pba_pkg::ST_SCAN:
            begin
                if (!limit_ok || hit)
                begin
                    state_next = pba_pkg::ST_FINISH;
                end
            end
            pba_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = pba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pba_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result values for each state.
    always_comb
    begin
        req_next       = req_reg;
        start_next     = start_reg;
        oldc_next      = oldc_reg;
        cnt_next       = cnt_reg;
        free_map_next  = free_map_reg;
        cnt_sh_next    = cnt_sh_reg;
        old_sh_next    = old_sh_reg;
        cand_next      = cand_reg;
        s_next         = s_reg;
        res_ok_next    = res_ok_reg;
        res_page_next  = res_page_reg;
        res_moved_next = res_moved_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_ok_next    = out_ok_reg;
        out_page_next  = out_page_reg;
        out_moved_next = out_moved_reg;
        out_map_next   = out_map_reg;

        unique case (state_reg)
            pba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = pba_pkg::req_t'(req_type);
                    start_next = start_page;
                    oldc_next  = old_count;
                    cnt_next   = page_count;
                end
            end
            pba_pkg::ST_SHIFT:
            begin
                // Place both runs at the start page and prime the scan.
                cnt_sh_next    = run_mask(cnt_reg) << start_reg;
                old_sh_next    = run_mask(oldc_reg) << start_reg;
                cand_next      = run_mask(cnt_reg);
                s_next         = '0;
                res_ok_next    = 1'b0;
                res_page_next  = '0;
                res_moved_next = 1'b0;
            end
            pba_pkg::ST_DECIDE:
            begin
                unique case (req_reg)
                    pba_pkg::REQ_ALLOC:
                    begin
                        res_ok_next = 1'b0;
                    end
                    pba_pkg::REQ_FREE:
                    begin
                        free_map_next = free_map_reg | cnt_sh_reg;
                        res_ok_next   = 1'b1;
                        res_page_next = start_reg;
                    end
                    pba_pkg::REQ_RESIZE:
                    begin
                        // Shrink frees the tail; growth takes the extension when free.
                        if (!old_busy && !grow)
                        begin
                            free_map_next = free_map_reg | delta;
                            res_ok_next   = 1'b1;
                            res_page_next = start_reg;
                        end
                        else if (!old_busy && ext_fits && ext_free)
                        begin
                            free_map_next = free_map_reg & ~delta;
                            res_ok_next   = 1'b1;
                            res_page_next = start_reg;
                        end
                    end
                    pba_pkg::REQ_RESET:
                    begin
                        free_map_next = run_mask(total_pages_reg);
                        res_ok_next   = 1'b1;
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end
            pba_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    // A relocated run takes its new pages and releases its old pages in the same map update.
                    if (req_reg == pba_pkg::REQ_RESIZE)
                    begin
                        free_map_next  = (free_map_reg & ~cand_reg) | old_sh_reg;
                        res_moved_next = 1'b1;
                    end
                    else
                    begin
                        free_map_next = free_map_reg & ~cand_reg;
                    end
                    res_ok_next   = 1'b1;
                    res_page_next = PW'(s_reg);
                end
                else if (limit_ok)
                begin
                    cand_next = cand_reg << 1;
                    s_next    = s_reg + SW'(1);
                end
            end
            pba_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_page_next  = res_page_reg;
                    out_moved_next = res_moved_reg;
                    out_map_next   = pba_pkg::OUT_MAP_W'(free_map_reg);
                end
            end
            default:
            begin
                s_next = '0;
            end
        endcase
    end

    // Control state and the free map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pba_pkg::ST_IDLE;
            total_pages_reg <= pba_pkg::TOTAL_PAGES_RESET;
            free_map_reg    <= run_mask(pba_pkg::TOTAL_PAGES_RESET);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_map_reg  <= free_map_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                total_pages_reg <= cfg_wr_data;
            end
        end
    end

    // Request fields, scan registers and result payload.
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        start_reg     <= start_next;
        oldc_reg      <= oldc_next;
        cnt_reg       <= cnt_next;
        cnt_sh_reg    <= cnt_sh_next;
        old_sh_reg    <= old_sh_next;
        cand_reg      <= cand_next;
        s_reg         <= s_next;
        res_ok_reg    <= res_ok_next;
        res_page_reg  <= res_page_next;
        res_moved_reg <= res_moved_next;
        out_ok_reg    <= out_ok_next;
        out_page_reg  <= out_page_next;
        out_moved_reg <= out_moved_next;
        out_map_reg   <= out_map_next;
    end

    assign in_ready     = (state_reg == pba_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign result_page  = out_page_reg;
    assign moved        = out_moved_reg;
    assign free_map_out = out_map_reg;

    // States in which the map is left alone, and the scan state.
    assign map_quiet = (state_reg == pba_pkg::ST_IDLE) || (state_reg == pba_pkg::ST_SHIFT)
                    || (state_reg == pba_pkg::ST_FINISH);
    assign in_scan   = (state_reg == pba_pkg::ST_SCAN);

    // The map only changes while a request is being decided or scanned.
    `ASSERT_NEXT(map_held_a, map_quiet, $stable(free_map_reg))
    // A successful scan step ends the search with a success.
    `ASSERT_NEXT(scan_hit_a, (in_scan && hit), (state_reg == pba_pkg::ST_FINISH && res_ok_reg))
    // The scan position never runs past the end of the map.
    `ASSERT_SAME(scan_range_a, in_scan, (s_reg <= SW'(MAP_BITS)))
    // A relocation is only ever reported together with success.
    `ASSERT_SAME(moved_ok_a, (out_valid_reg && out_moved_reg), out_ok_reg)

endmodule
